FILE: hw/rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BRD_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define BRD_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define BRD_ASSERT(label, clk, rstn, prop)
`define BRD_ASSERT_RST(label, clk, prop)
`endif
`endif

FILE: hw/rtl/brd_pkg.sv
package brd_pkg;
  localparam int unsigned Depth   = 4096;
  localparam int unsigned MaxRead = 64;
  localparam int unsigned AW      = $clog2(Depth);
  localparam int unsigned CW      = 13;

  typedef enum logic [2:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_DROP_FRONT = 3'd4,
    FN_DROP_BACK  = 3'd5,
    FN_CLEAR      = 3'd6,
    FN_NONE       = 3'd7
  } func_e;

  // front -> back command
  typedef struct packed {
    logic          wr;      // store write
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          rd;      // read run
    logic [AW-1:0] raddr;
    logic [6:0]    n;       // bytes to read (>0 when rd)
    logic [CW-1:0] amount;
    logic          status;
    logic [CW-1:0] fill;
  } cmd_t;

  typedef struct packed {
    logic [7:0]    byte_out;
    logic          byte_valid;
    logic [CW-1:0] amount;
    logic          status;
    logic          last;
    logic [CW-1:0] fill;
  } res_t;
endpackage

FILE: hw/rtl/brd_front.sv
module brd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [12:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             func_i,
  input  logic [7:0]             data_i,
  input  logic [12:0]            count_i,
  input  logic                   start_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output brd_pkg::cmd_t          cmd_o
);
  localparam int unsigned AW = brd_pkg::AW;
  localparam int unsigned CW = brd_pkg::CW;

  logic [CW-1:0] cap_q, cap_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d, gp_q, gp_d;
  logic [CW-1:0] fill_q, fill_d, left_q, left_d;
  logic          acc_q, acc_d;
  logic [CW-1:0] cap_eff;
  logic [CW:0]   sum;
  logic [CW-1:0] n;
  logic          fire;
  brd_pkg::func_e fn;

  function automatic logic [CW-1:0] wadd(logic [CW-1:0] a, logic [CW-1:0] b,
                                         logic [CW-1:0] c);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, c}) s = s - {1'b0, c};
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] wsub(logic [CW-1:0] a, logic [CW-1:0] b,
                                         logic [CW-1:0] c);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, c} - {1'b0, b};
    if (s >= {1'b0, c}) s = s - {1'b0, c};
    return s[CW-1:0];
  endfunction

  assign cap_d = cfg_wdata_i;
  assign cap_eff = (cap_q == '0) ? CW'(1) :
                   (cap_q > CW'(brd_pkg::Depth)) ? CW'(brd_pkg::Depth) : cap_q;
  assign fn = brd_pkg::func_e'(func_i);
  assign in_ready_o = cmd_ready_i;
  assign fire = in_valid_i && in_ready_o;
  assign sum = {1'b0, fill_q} + {1'b0, count_i};

  always_comb begin
    head_d = head_q; tail_d = tail_q; gp_d = gp_q; fill_d = fill_q;
    left_d = left_q; acc_d = acc_q;
    cmd_o = '0;
    n = '0;
    if (fn == brd_pkg::FN_PUSH_BACK || fn == brd_pkg::FN_PUSH_FRONT) begin
      if (start_i) begin
        if (sum <= {1'b0, cap_eff}) begin
          acc_d = 1'b1;
          left_d = count_i;
          fill_d = sum[CW-1:0];
          if (fn == brd_pkg::FN_PUSH_BACK) begin
            gp_d = tail_q;
            tail_d = AW'(wadd(CW'(tail_q), count_i, cap_eff));
          end else begin
            head_d = AW'(wsub(CW'(head_q), count_i, cap_eff));
            gp_d = head_d;
          end
        end else begin
          acc_d = 1'b0;
          left_d = '0;
          cmd_o.status = 1'b1;
        end
      end else if (!acc_q) begin
        cmd_o.status = 1'b1;
      end
      if (acc_d && left_d != '0) begin
        cmd_o.wr = 1'b1;
        cmd_o.waddr = gp_d;
        cmd_o.wdata = data_i;
        gp_d = AW'(wadd(CW'(gp_d), CW'(1), cap_eff));
        left_d = left_d - CW'(1);
      end
    end else begin
      left_d = '0;
      if (fn == brd_pkg::FN_POP_FRONT || fn == brd_pkg::FN_POP_BACK) begin
        n = (count_i > CW'(brd_pkg::MaxRead)) ? CW'(brd_pkg::MaxRead) : count_i;
        if (n > fill_q) n = fill_q;
        if (fn == brd_pkg::FN_POP_FRONT) begin
          cmd_o.raddr = head_q;
          head_d = AW'(wadd(CW'(head_q), n, cap_eff));
        end else begin
          tail_d = AW'(wsub(CW'(tail_q), n, cap_eff));
          cmd_o.raddr = tail_d;
        end
        fill_d = fill_q - n;
        cmd_o.rd = (n != '0);
        cmd_o.n = n[6:0];
        cmd_o.amount = n;
      end else if (fn == brd_pkg::FN_DROP_FRONT || fn == brd_pkg::FN_DROP_BACK) begin
        n = (count_i > fill_q) ? fill_q : count_i;
        if (fn == brd_pkg::FN_DROP_FRONT) head_d = AW'(wadd(CW'(head_q), n, cap_eff));
        else tail_d = AW'(wsub(CW'(tail_q), n, cap_eff));
        fill_d = fill_q - n;
        cmd_o.amount = n;
      end else if (fn == brd_pkg::FN_CLEAR) begin
        head_d = '0; tail_d = '0; fill_d = '0; gp_d = '0; acc_d = 1'b0;
      end
    end
    cmd_o.fill = fill_d;
  end

  assign cmd_valid_o = in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CW'(brd_pkg::Depth);
      head_q <= '0; tail_q <= '0; gp_q <= '0; fill_q <= '0; left_q <= '0;
      acc_q <= 1'b0;
    end else if (cfg_we_i) begin
      cap_q <= cap_d;
      head_q <= '0; tail_q <= '0; gp_q <= '0; fill_q <= '0; left_q <= '0;
      acc_q <= 1'b0;
    end else if (fire) begin
      head_q <= head_d; tail_q <= tail_d; gp_q <= gp_d; fill_q <= fill_d;
      left_q <= left_d; acc_q <= acc_d;
    end
  end
endmodule

FILE: hw/rtl/brd_queue.sv
module brd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  brd_pkg::cmd_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output brd_pkg::cmd_t out_o
);
  brd_pkg::cmd_t mem_q [2];
  logic [1:0] wp_q, rp_q;
  logic [1:0] cnt;

  assign cnt = wp_q - rp_q;
  assign in_ready_o = (cnt != 2'd2);
  assign out_valid_o = (cnt != 2'd0);
  assign out_o = mem_q[rp_q[0]];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mem_q[wp_q[0]] <= in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0;
    end else begin
      if (in_valid_i && in_ready_o) wp_q <= wp_q + 2'd1;
      if (out_valid_o && out_ready_i) rp_q <= rp_q + 2'd1;
    end
  end
endmodule

FILE: hw/rtl/brd_back.sv
module brd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [12:0]   cap_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  brd_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output brd_pkg::res_t res_o
);
  localparam int unsigned AW = brd_pkg::AW;
  localparam int unsigned CW = brd_pkg::CW;

  logic [7:0]    mem_q [brd_pkg::Depth];
  logic [7:0]    rdata_q;
  logic          busy_q;
  logic [AW-1:0] ra_q;
  logic [6:0]    i_q;
  logic          rv_q;       // read data pending to output reg
  logic          rlast_q;
  brd_pkg::cmd_t cur_q;
  logic          ov_q;
  brd_pkg::res_t ov_res_q;
  logic          out_free, issue, take;
  logic [CW-1:0] cap_eff;
  logic [AW-1:0] ra_nx;
  logic [CW:0]   s;

  assign cap_eff = (cap_i == '0) ? CW'(1) :
                   (cap_i > CW'(brd_pkg::Depth)) ? CW'(brd_pkg::Depth) : cap_i;
  // output reg free next cycle
  assign out_free = !ov_q || res_ready_i;
  assign take = cmd_valid_i && !busy_q && !rv_q && out_free;
  assign cmd_ready_o = take;
  assign issue = busy_q && !rv_q && out_free;

  always_comb begin
    s = {1'b0, CW'(ra_q)} + {{CW{1'b0}}, 1'b1};
    if (s >= {1'b0, cap_eff}) s = s - {1'b0, cap_eff};
    ra_nx = s[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.wr) mem_q[cmd_i.waddr] <= cmd_i.wdata;
    rdata_q <= mem_q[ra_q];
    if (take) cur_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; rv_q <= 1'b0; ov_q <= 1'b0; ra_q <= '0; i_q <= '0;
      rlast_q <= 1'b0; ov_res_q <= '0;
    end else begin
      if ((take && !cmd_i.rd) || rv_q) ov_q <= 1'b1;
      else if (res_ready_i) ov_q <= 1'b0;
      if (take) begin
        if (cmd_i.rd) begin
          busy_q <= 1'b1;
          ra_q <= cmd_i.raddr;
          i_q <= 7'd1;
        end else begin
          ov_res_q <= '{byte_out: 8'd0, byte_valid: 1'b0, amount: cmd_i.amount,
                        status: cmd_i.status, last: 1'b1, fill: cmd_i.fill};
        end
      end
      rv_q <= issue;
      if (issue) begin
        rlast_q <= (i_q == cur_q.n);
        ra_q <= ra_nx;
        i_q <= i_q + 7'd1;
        if (i_q == cur_q.n) busy_q <= 1'b0;
      end
      if (rv_q) begin
        ov_res_q <= '{byte_out: rdata_q, byte_valid: 1'b1, amount: cur_q.amount,
                      status: 1'b0, last: rlast_q, fill: cur_q.fill};
      end
    end
  end

  assign res_valid_o = ov_q;
  assign res_o = ov_res_q;
endmodule

FILE: hw/rtl/byte_ring_deque_top.sv
// Byte ring deque.
// Input stream s_axis: one operation per transfer (push back/front, pop
// front/back, drop front/back, clear). tuser carries group_start. Push groups
// give their length on the first byte and are accepted or rejected whole.
// Output stream m_axis: one transfer per result; a pop of n bytes gives n
// transfers in memory order, tlast on the final one; other items give one.
// tuser on the output marks a transfer that carries a popped byte.
// Front stage updates pointers and fill level and feeds a two-entry command
// queue to the back stage that owns the store, one item per cycle while the
// queue has room. Non-pop results pass the queue and the output register;
// popped bytes also pass the read-data register. The back stage takes one
// non-pop item per cycle while the output register is free; a pop of n bytes
// holds it until all are read, one by one, through the single store read port.
// Reset clears pointers, fill and group state; capacity resets to 4096.
// A capacity write empties the deque. When m_axis_tready is low the output
// register holds and the queue fills, then s_axis_tready drops.
module byte_ring_deque_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // func[2:0], data[10:3], count[23:11]
  input  logic        s_axis_tuser,  // group_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // byte_out[7:0], amount[20:8], status[21],
                                     // fill[34:22]
  output logic        m_axis_tuser,  // byte_valid
  output logic        m_axis_tlast
);
  `include "assert_macros.svh"

  logic          cmd_v, cmd_r, q_v, q_r;
  brd_pkg::cmd_t cmd, qcmd;
  brd_pkg::res_t res;
  logic [12:0]   cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 13'(brd_pkg::Depth);
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  brd_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .func_i(s_axis_tdata[2:0]), .data_i(s_axis_tdata[10:3]),
    .count_i(s_axis_tdata[23:11]), .start_i(s_axis_tuser),
    .cmd_valid_o(cmd_v), .cmd_ready_i(cmd_r), .cmd_o(cmd)
  );

  brd_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(cmd_v), .in_ready_o(cmd_r), .in_i(cmd),
    .out_valid_o(q_v), .out_ready_i(q_r), .out_o(qcmd)
  );

  brd_back u_back (
    .clk_i, .rst_ni, .cap_i(cap_q), .cmd_valid_i(q_v), .cmd_ready_o(q_r),
    .cmd_i(qcmd), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_o(res)
  );

  assign m_axis_tdata = {5'b0, res.fill, res.status, res.amount, res.byte_out};
  assign m_axis_tuser = res.byte_valid;
  assign m_axis_tlast = res.last;

  `BRD_ASSERT(a_pop_amount, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[20:8] != 13'd0))
  `BRD_ASSERT(a_fill_max, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[34:22] <= 13'(brd_pkg::Depth)))
  `BRD_ASSERT(a_status_nobyte, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tdata[21]) |-> (!m_axis_tuser && m_axis_tlast))
endmodule
